### rtl/mmid_pkg.sv
// Shared constants and types for the min/max interleaved decimator.
`timescale 1ns / 1ps
package mmid_pkg;

  localparam int FACTOR_BITS  = 16;
  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;
  localparam int REG_IDX_LSB  = 2;

  localparam logic [FACTOR_BITS-1:0] FACTOR_MIN   = 16'd2;
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd2;

  typedef enum logic {
    REG_DECIMATION_FACTOR = 1'b0
  } reg_idx_t;

  // Status of the pair queue as seen by the front and back parts.
  typedef struct packed {
    logic can_push;
    logic has_data;
  } qstat_t;

endpackage

### rtl/mmid_if.sv
// Valid/ready channel interfaces for samples in and results out.
`timescale 1ns / 1ps
interface mmid_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface mmid_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          last_of_pair;

  modport source (output valid, output out_sample, output last_of_pair, input ready);
  modport sink (input valid, input out_sample, input last_of_pair, output ready);
endinterface

### rtl/mmid_front.sv
// Front part: accepts samples, tracks the group and orders the min/max pair.
`timescale 1ns / 1ps
module mmid_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  mmid_sample_if.sink                            sample_ch,
  input  logic [mmid_pkg::FACTOR_BITS-1:0]       factor,
  input  mmid_pkg::qstat_t                       qstat,
  output logic                                   push,
  output logic signed [SAMPLE_BITS-1:0]          pair_first,
  output logic signed [SAMPLE_BITS-1:0]          pair_second
);
  import mmid_pkg::*;

  logic [FACTOR_BITS-1:0]        pos;
  logic [FACTOR_BITS-1:0]        pos_next;
  logic signed [SAMPLE_BITS-1:0] group_first;
  logic signed [SAMPLE_BITS-1:0] running_min;
  logic signed [SAMPLE_BITS-1:0] running_max;
  logic signed [SAMPLE_BITS-1:0] first_cur;
  logic signed [SAMPLE_BITS-1:0] min_cur;
  logic signed [SAMPLE_BITS-1:0] max_cur;
  logic [FACTOR_BITS-1:0]        eff_factor;
  logic [FACTOR_BITS:0]          pos_inc;
  logic                          closing;
  logic                          rising;
  logic                          xfer;

  assign sample_ch.ready = qstat.can_push;
  assign xfer            = sample_ch.valid && sample_ch.ready;

  // Factors of zero and one behave as two.
  assign eff_factor = (factor < FACTOR_MIN) ? FACTOR_MIN : factor;
  assign pos_inc    = {1'b0, pos} + {{FACTOR_BITS{1'b0}}, 1'b1};
  assign closing    = pos_inc >= {1'b0, eff_factor};

  always_comb begin
    if (pos == '0) begin
      first_cur = sample_ch.sample_in;
      min_cur   = sample_ch.sample_in;
      max_cur   = sample_ch.sample_in;
    end else begin
      first_cur = group_first;
      min_cur   = (sample_ch.sample_in < running_min) ? sample_ch.sample_in : running_min;
      max_cur   = (sample_ch.sample_in > running_max) ? sample_ch.sample_in : running_max;
    end
    rising      = sample_ch.sample_in > first_cur;
    pair_first  = rising ? min_cur : max_cur;
    pair_second = rising ? max_cur : min_cur;
    pos_next    = closing ? '0 : pos_inc[FACTOR_BITS-1:0];
  end

  assign push = xfer && closing;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (xfer) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      group_first <= first_cur;
      running_min <= min_cur;
      running_max <= max_cur;
    end
  end
endmodule

### rtl/mmid_queue.sv
// Two-entry queue of ordered min/max pairs between the front and back parts.
`timescale 1ns / 1ps
module mmid_queue #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] push_first,
  input  logic signed [SAMPLE_BITS-1:0] push_second,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] head_first,
  output logic signed [SAMPLE_BITS-1:0] head_second,
  output mmid_pkg::qstat_t              qstat
);
  import mmid_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem_first  [2];
  logic signed [SAMPLE_BITS-1:0] mem_second [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;

  assign qstat.can_push = count != 2'd2;
  assign qstat.has_data = count != 2'd0;
  assign head_first     = mem_first[rd_ptr];
  assign head_second    = mem_second[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_first[wr_ptr]  <= push_first;
      mem_second[wr_ptr] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

### rtl/mmid_back.sv
// Back part: plays each queued pair out as two results, the second flagged last.
`timescale 1ns / 1ps
module mmid_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mmid_pkg::qstat_t              qstat,
  input  logic signed [SAMPLE_BITS-1:0] head_first,
  input  logic signed [SAMPLE_BITS-1:0] head_second,
  output logic                          pop,
  mmid_result_if.source                 result_ch
);
  import mmid_pkg::*;

  logic                          busy;
  logic                          phase;
  logic signed [SAMPLE_BITS-1:0] first_q;
  logic signed [SAMPLE_BITS-1:0] second_q;
  logic                          xfer;

  assign result_ch.valid        = busy;
  assign result_ch.out_sample   = phase ? second_q : first_q;
  assign result_ch.last_of_pair = phase;

  assign xfer = busy && result_ch.ready;
  // A new pair loads when the register is empty or its last result leaves now.
  assign pop  = qstat.has_data && (!busy || (phase && xfer));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (pop) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (xfer) begin
      busy  <= !phase;
      phase <= !phase;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      first_q  <= head_first;
      second_q <= head_second;
    end
  end
endmodule

### rtl/min_max_interleaved_decimator.sv
// A closing sample writes its group's pair to the queue, then to the back part's register.
// Throughput: one sample per cycle unless the queue is full; a group yields two results.
// Any factor of two or more keeps the result side at or below one result per cycle.
// A two-entry pair queue lets the sample and result sides stall independently.
// Reset (rst, synchronous) sets the factor to two, opens a new group and empties all stages.
`timescale 1ns / 1ps
module min_max_interleaved_decimator #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  mmid_sample_if.sink                         sample_ch,
  mmid_result_if.source                       result_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mmid_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [mmid_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [mmid_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                pready
);
  import mmid_pkg::*;

  logic [FACTOR_BITS-1:0]        factor;
  reg_idx_t                      reg_idx;
  logic                          push;
  logic                          pop;
  logic signed [SAMPLE_BITS-1:0] push_first;
  logic signed [SAMPLE_BITS-1:0] push_second;
  logic signed [SAMPLE_BITS-1:0] head_first;
  logic signed [SAMPLE_BITS-1:0] head_second;
  qstat_t                        qstat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[REG_IDX_LSB]);

  always_comb begin
    case (reg_idx)
      REG_DECIMATION_FACTOR: prdata = {{(PDATA_BITS-FACTOR_BITS){1'b0}}, factor};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_DECIMATION_FACTOR) begin
      factor <= pwdata[FACTOR_BITS-1:0];
    end
  end

  mmid_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample_ch   (sample_ch),
    .factor      (factor),
    .qstat       (qstat),
    .push        (push),
    .pair_first  (push_first),
    .pair_second (push_second)
  );

  mmid_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_first  (push_first),
    .push_second (push_second),
    .pop         (pop),
    .head_first  (head_first),
    .head_second (head_second),
    .qstat       (qstat)
  );

  mmid_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .head_first  (head_first),
    .head_second (head_second),
    .pop         (pop),
    .result_ch   (result_ch)
  );
endmodule
